// ----- hw/rtl/dtq_pkg.sv -----
// Shared types, codes and field widths of the deadline timer queue.
package dtq_pkg;

    localparam int DEF_TIMER_SLOTS = 16;
    localparam int DEF_TIME_BITS   = 32;

    localparam int ACT_W      = 2;
    localparam int DLY_W      = 31;
    localparam int TID_W      = 4;
    localparam int STATUS_W   = 3;
    localparam int RID_W      = 4;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - STATUS_W - RID_W;

    localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CANCEL = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TICK   = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        STAT_ADDED     = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_CANCELLED = 3'd2,
        STAT_NO_ID     = 3'd3,
        STAT_FIRED     = 3'd4
    } t_status;

    // Control that travels with one slot entry read back during a scan.
    typedef struct packed {
        logic vld;
        logic first;
        logic active;
        logic due;
    } t_ev_ctl;

endpackage

// ----- hw/rtl/dtq_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module dtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/dtq_select.sv -----
// Due test and oldest-deadline selection over the slot entries streamed by a scan.
module dtq_select #(
    parameter int TIMER_SLOTS = dtq_pkg::DEF_TIMER_SLOTS,
    parameter int TIME_BITS   = dtq_pkg::DEF_TIME_BITS
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_clr,
    input  dtq_pkg::t_ev_ctl                          i_ctl,
    input  logic [$clog2(TIMER_SLOTS)-1:0]            i_idx,
    input  logic [TIME_BITS+dtq_pkg::DLY_W:0]         i_word,
    input  logic [TIME_BITS-1:0]                      i_time,
    output logic                                      o_cand,
    output logic                                      o_best_vld,
    output logic [$clog2(TIMER_SLOTS)-1:0]            o_best_idx,
    output logic [dtq_pkg::DLY_W-1:0]                 o_best_per,
    output logic                                      o_best_rep
);
    import dtq_pkg::*;

    localparam int IDX_W  = $clog2(TIMER_SLOTS);
    localparam int WORD_W = TIME_BITS + DLY_W + 1;

    logic [TIME_BITS-1:0] w_deadline;
    logic [TIME_BITS-1:0] w_age;
    logic                 w_take;

    logic                 r_vld;
    logic [IDX_W-1:0]     r_idx;
    logic [TIME_BITS-1:0] r_age;
    logic [DLY_W-1:0]     r_per;
    logic                 r_rep;

    assign w_deadline = i_word[TIME_BITS-1:0];
    assign w_age      = i_time - w_deadline;
    // First pass decides who is due; later passes reuse the due bits.
    assign o_cand     = i_ctl.first ? (i_ctl.active && !w_age[TIME_BITS-1]) : i_ctl.due;
    // Strict compare keeps the lower id on equal age, since ids arrive in order.
    assign w_take     = i_ctl.vld && o_cand && (!r_vld || (w_age > r_age));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_clr) begin
            r_vld <= 1'b0;
        end else if (w_take) begin
            r_vld <= 1'b1;
            r_idx <= i_idx;
            r_age <= w_age;
            r_per <= i_word[TIME_BITS +: DLY_W];
            r_rep <= i_word[WORD_W-1];
        end
    end

    assign o_best_vld = r_vld;
    assign o_best_idx = r_idx;
    assign o_best_per = r_per;
    assign o_best_rep = r_rep;

endmodule

// ----- hw/rtl/deadline_timer_queue.sv -----
// Top level of the deadline timer queue: request decode, slot bits, scan sequencer, output.
//
// A table of TIMER_SLOTS timers against a TIME_BITS-bit tick counter. Requests carry the
// action in tuser: add takes the lowest free slot and answers with its id (or table full),
// cancel frees a slot by id, tick advances time by one and reports every due timer, oldest
// deadline first and lower id first on a tie, re-arming periodic ones. Deadline, period and
// repeat mark of each slot live in one RAM with one read port, so a tick is worked as scans
// of the whole table: each scan issues the reads, waits on the registered read data, selects
// and updates, and one scan is run per fired timer (at least one per tick), each fired timer
// then passing the result stage, which waits while the output register is full. A new
// request is taken while the last result still waits in the output register.
module deadline_timer_queue #(
    parameter int TIMER_SLOTS = dtq_pkg::DEF_TIMER_SLOTS,
    parameter int TIME_BITS   = dtq_pkg::DEF_TIME_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [30:0] delay, [31] periodic, [35:32] timer_id, [39:36] zero
    input  logic [dtq_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [1:0] action
    input  logic [dtq_pkg::ACT_W-1:0]          s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [2:0] status, [6:3] result_id, [7] zero
    output logic [dtq_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                               m_axis_tlast
);
    import dtq_pkg::*;

    localparam int IDX_W  = $clog2(TIMER_SLOTS);
    localparam int WORD_W = TIME_BITS + DLY_W + 1;
    localparam int EXT_W  = (TIME_BITS > DLY_W) ? TIME_BITS : DLY_W;
    localparam logic [EXT_W-1:0] HALF_M1   = EXT_W'({(TIME_BITS-1){1'b1}});
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TIMER_SLOTS - 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN, S_RESULT} t_state;

    t_state                 r_state;
    logic [TIME_BITS-1:0]   r_time;
    logic [TIMER_SLOTS-1:0] r_active;
    logic [TIMER_SLOTS-1:0] r_due;
    logic [IDX_W-1:0]       r_iss;
    logic                   r_issuing;
    logic                   r_first;
    logic                   r_ev_vld;
    logic [IDX_W-1:0]       r_ev_idx;
    t_status                r_res_status;
    logic [RID_W-1:0]       r_res_id;
    logic                   r_res_last;
    logic                   r_out_vld;
    t_status                r_out_status;
    logic [RID_W-1:0]       r_out_id;
    logic                   r_out_last;

    logic [DLY_W-1:0]       w_delay;
    logic                   w_periodic;
    logic [TID_W-1:0]       w_tid;
    logic [ACT_W-1:0]       w_action;
    logic                   w_accept;
    logic                   w_free_vld;
    logic [IDX_W-1:0]       w_free_idx;
    logic [EXT_W-1:0]       w_dext;
    logic                   w_tid_ok;
    logic                   w_we;
    logic [IDX_W-1:0]       w_waddr;
    logic [WORD_W-1:0]      w_wdata;
    logic [WORD_W-1:0]      w_rdata;
    logic                   w_out_free;
    logic                   w_scan_go;
    logic                   w_last_ev;
    logic [TIMER_SLOTS-1:0] w_rest;
    t_ev_ctl                w_ctl;
    logic                   w_cand;
    logic                   w_best_vld;
    logic [IDX_W-1:0]       w_best_idx;
    logic [DLY_W-1:0]       w_best_per;
    logic                   w_best_rep;

    assign w_delay    = s_axis_tdata[DLY_W-1:0];
    assign w_periodic = s_axis_tdata[DLY_W];
    assign w_tid      = s_axis_tdata[DLY_W+1 +: TID_W];
    assign w_action   = s_axis_tuser;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_vld || m_axis_tready;

    // Lowest free slot.
    always_comb begin
        w_free_vld = 1'b0;
        w_free_idx = '0;
        for (int s = TIMER_SLOTS - 1; s >= 0; s--) begin
            if (!r_active[s]) begin
                w_free_vld = 1'b1;
                w_free_idx = IDX_W'(s);
            end
        end
    end

    // Force delay into 1 .. 2^(TIME_BITS-1)-1.
    always_comb begin
        w_dext = EXT_W'(w_delay);
        if (w_dext == '0) begin
            w_dext = EXT_W'(1);
        end
        if (w_dext > HALF_M1) begin
            w_dext = HALF_M1;
        end
    end

    assign w_tid_ok = (32'(w_tid) < 32'(TIMER_SLOTS)) && r_active[IDX_W'(w_tid)];

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_free_idx;
        w_wdata = {w_periodic, w_dext[DLY_W-1:0], r_time + w_dext[TIME_BITS-1:0]};
        if (r_state == S_IDLE) begin
            w_we = w_accept && (w_action == ACT_ADD) && w_free_vld;
        end else if (r_state == S_FIN) begin
            // Re-arm a fired periodic timer from the new time.
            w_we    = w_best_vld && w_best_rep;
            w_waddr = w_best_idx;
            w_wdata = {1'b1, w_best_per, r_time + TIME_BITS'(w_best_per)};
        end
    end

    assign w_scan_go = ((r_state == S_IDLE) && w_accept && (w_action == ACT_TICK)) ||
                       ((r_state == S_RESULT) && w_out_free && !r_res_last);
    assign w_last_ev = r_ev_vld && (r_ev_idx == LAST_SLOT);
    assign w_rest    = r_due & ~(TIMER_SLOTS'(1) << w_best_idx);

    assign w_ctl.vld    = r_ev_vld;
    assign w_ctl.first  = r_first;
    assign w_ctl.active = r_active[r_ev_idx];
    assign w_ctl.due    = r_due[r_ev_idx];

    dtq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TIMER_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_iss),
        .o_rdata (w_rdata)
    );

    dtq_select #(
        .TIMER_SLOTS (TIMER_SLOTS),
        .TIME_BITS   (TIME_BITS)
    ) u_select (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clr      (w_scan_go),
        .i_ctl      (w_ctl),
        .i_idx      (r_ev_idx),
        .i_word     (w_rdata),
        .i_time     (r_time),
        .o_cand     (w_cand),
        .o_best_vld (w_best_vld),
        .o_best_idx (w_best_idx),
        .o_best_per (w_best_per),
        .o_best_rep (w_best_rep)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_time    <= '0;
            r_active  <= '0;
            r_due     <= '0;
            r_issuing <= 1'b0;
            r_ev_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            // The result stage reloads the output register itself.
            if (r_out_vld && m_axis_tready && (r_state != S_RESULT)) begin
                r_out_vld <= 1'b0;
            end

            // Read issue and evaluate stage of a scan.
            r_ev_vld <= r_issuing;
            r_ev_idx <= r_iss;
            if (r_issuing) begin
                if (r_iss == LAST_SLOT) begin
                    r_issuing <= 1'b0;
                end else begin
                    r_iss <= r_iss + 1'b1;
                end
            end
            if (r_ev_vld) begin
                r_due[r_ev_idx] <= w_cand;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (w_action)
                            ACT_ADD: begin
                                r_res_last <= 1'b1;
                                r_state    <= S_RESULT;
                                if (w_free_vld) begin
                                    r_active[w_free_idx] <= 1'b1;
                                    r_res_status <= STAT_ADDED;
                                    r_res_id     <= RID_W'(w_free_idx);
                                end else begin
                                    r_res_status <= STAT_FULL;
                                    r_res_id     <= '0;
                                end
                            end
                            ACT_CANCEL: begin
                                r_res_last <= 1'b1;
                                r_res_id   <= w_tid;
                                r_state    <= S_RESULT;
                                if (w_tid_ok) begin
                                    r_active[IDX_W'(w_tid)] <= 1'b0;
                                    r_res_status <= STAT_CANCELLED;
                                end else begin
                                    r_res_status <= STAT_NO_ID;
                                end
                            end
                            ACT_TICK: begin
                                r_time    <= r_time + 1'b1;
                                r_iss     <= '0;
                                r_issuing <= 1'b1;
                                r_first   <= 1'b1;
                                r_state   <= S_SCAN;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (w_last_ev) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_best_vld) begin
                        r_due[w_best_idx] <= 1'b0;
                        if (!w_best_rep) begin
                            r_active[w_best_idx] <= 1'b0;
                        end
                        r_res_status <= STAT_FIRED;
                        r_res_id     <= RID_W'(w_best_idx);
                        r_res_last   <= (w_rest == '0);
                        r_state      <= S_RESULT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_RESULT: begin
                    if (w_out_free) begin
                        r_out_vld    <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_id     <= r_res_id;
                        r_out_last   <= r_res_last;
                        if (r_res_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            // Next scan picks the next oldest due timer.
                            r_iss     <= '0;
                            r_issuing <= 1'b1;
                            r_first   <= 1'b0;
                            r_state   <= S_SCAN;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_id, r_out_status};
    assign m_axis_tlast  = r_out_last;

    a_ev_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ev_vld |-> (r_state == S_SCAN))
        else $error("scan read data outside a scan");

    a_idle_no_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_due == '0))
        else $error("due timers left behind at end of tick");

    a_due_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_due & ~r_active) == '0)
        else $error("due bit set on an inactive slot");

    a_more_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RESULT) && !r_res_last) |-> (r_due != '0))
        else $error("further scan requested with nothing due");

    a_rescan_finds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && !r_first) |-> w_best_vld)
        else $error("later scan found no due timer");

endmodule

// ----- bench/tb_deadline_timer_queue.sv -----
// Testbench for the deadline timer queue: directed and random requests against a timer model.
`timescale 1ns / 1ps

module tb_deadline_timer_queue;
    import dtq_pkg::*;

    localparam int SLOTS        = DEF_TIMER_SLOTS;
    localparam int TBITS        = DEF_TIME_BITS;
    localparam int DRAIN_CYCLES = 400;
    localparam int CYCLE_LIMIT  = 1_000_000;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic [DLY_W-1:0] DLY_MAX    = '1;

    typedef struct {
        t_status          status;
        logic [RID_W-1:0] rid;
        logic             last;
    } t_timer_result;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [ACT_W-1:0]      s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    // Timer table as the block should hold it.
    logic             timer_on      [SLOTS] = '{default: 1'b0};
    logic [TBITS-1:0] timer_due_at  [SLOTS] = '{default: '0};
    logic [DLY_W-1:0] timer_period  [SLOTS] = '{default: '0};
    logic             timer_repeats [SLOTS] = '{default: 1'b0};
    logic [TBITS-1:0] tick_count = '0;

    t_timer_result expected_results[$];

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int errors          = 0;
    int requests_sent   = 0;
    int results_checked = 0;
    int fires_predicted = 0;
    int fulls_predicted = 0;
    int cycle_count     = 0;

    deadline_timer_queue dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycle_count,
                     expected_results.size());
            $display("deadline_timer_queue: mismatch");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("[%0t] check failed: %s", $time, msg);
    endtask

    function automatic void expect_result(input t_status st, input int id, input logic last);
        t_timer_result r;
        r.status = st;
        r.rid    = RID_W'(id);
        r.last   = last;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_request(input logic [ACT_W-1:0] act,
                                            input logic [DLY_W-1:0] dly,
                                            input logic per,
                                            input logic [TID_W-1:0] tid);
        int s;
        int slot;
        int best;
        logic due_now [SLOTS];
        logic [TBITS-1:0] age;
        logic [TBITS-1:0] best_age;
        int fired_ids[$];
        case (act)
            ACT_ADD: begin
                slot = -1;
                for (s = SLOTS - 1; s >= 0; s--)
                    if (!timer_on[s]) slot = s;
                if (slot < 0) begin
                    fulls_predicted++;
                    expect_result(STAT_FULL, 0, 1'b1);
                end else begin
                    // A zero delay would refire forever; it counts as one tick.
                    timer_on[slot]      = 1'b1;
                    timer_period[slot]  = (dly == '0) ? DLY_W'(1) : dly;
                    timer_repeats[slot] = per;
                    timer_due_at[slot]  = tick_count + TBITS'(timer_period[slot]);
                    expect_result(STAT_ADDED, slot, 1'b1);
                end
            end
            ACT_CANCEL: begin
                if (timer_on[tid]) begin
                    timer_on[tid] = 1'b0;
                    expect_result(STAT_CANCELLED, int'(tid), 1'b1);
                end else begin
                    expect_result(STAT_NO_ID, int'(tid), 1'b1);
                end
            end
            ACT_TICK: begin
                tick_count = tick_count + 1'b1;
                // Due when the wrapped age since the deadline has its top bit clear.
                for (s = 0; s < SLOTS; s++) begin
                    age        = tick_count - timer_due_at[s];
                    due_now[s] = timer_on[s] && !age[TBITS-1];
                end
                best = 0;
                while (best >= 0) begin
                    best     = -1;
                    best_age = '0;
                    for (s = 0; s < SLOTS; s++) begin
                        age = tick_count - timer_due_at[s];
                        if (due_now[s] && (best < 0 || age > best_age)) begin
                            best     = s;
                            best_age = age;
                        end
                    end
                    if (best >= 0) begin
                        due_now[best] = 1'b0;
                        fired_ids.push_back(best);
                        if (timer_repeats[best])
                            timer_due_at[best] = tick_count + TBITS'(timer_period[best]);
                        else
                            timer_on[best] = 1'b0;
                    end
                end
                foreach (fired_ids[i])
                    expect_result(STAT_FIRED, fired_ids[i], i == fired_ids.size() - 1);
                fires_predicted += fired_ids.size();
            end
            default: ;
        endcase
    endfunction

    task automatic send_request(input logic [ACT_W-1:0] act, input logic [DLY_W-1:0] dly,
                                input logic per, input logic [TID_W-1:0] tid);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {{(IN_DATA_W - DLY_W - 1 - TID_W){1'b0}}, tid, per, dly};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_request(act, dly, per, tid);
        requests_sent++;
    endtask

    always @(posedge i_clk) begin : check_result
        t_timer_result want;
        logic [STATUS_W-1:0] got_status;
        logic [RID_W-1:0] got_id;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_checked++;
            got_status = m_axis_tdata[STATUS_W-1:0];
            got_id     = m_axis_tdata[STATUS_W +: RID_W];
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d id %0d last %0b",
                                          got_status, got_id, m_axis_tlast));
            end else begin
                want = expected_results.pop_front();
                if (got_status !== want.status)
                    report_mismatch($sformatf("status %0d, want %s (id %0d)",
                                              got_status, want.status.name(), want.rid));
                if (got_id !== want.rid)
                    report_mismatch($sformatf("result id %0d, want %0d (%s)",
                                              got_id, want.rid, want.status.name()));
                if (m_axis_tlast !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b (id %0d)",
                                              m_axis_tlast, want.last, want.rid));
            end
        end
    end

    task automatic test_quiet_and_unused();
        send_request(ACT_TICK, '0, 1'b0, '0);
        send_request(ACT_UNUSED, DLY_MAX, 1'b1, '1);
        send_request(ACT_CANCEL, '0, 1'b0, '1);
    endtask

    task automatic test_add_fire_cancel();
        send_request(ACT_ADD, '0, 1'b0, '0);
        // Far deadline: stays not due until it is cancelled.
        send_request(ACT_ADD, DLY_MAX, 1'b1, '0);
        send_request(ACT_ADD, DLY_W'(1), 1'b1, '0);
        send_request(ACT_ADD, DLY_W'(2), 1'b0, '0);
        send_request(ACT_TICK, '0, 1'b0, '0);
        // Re-armed periodic and one-shot meet on one deadline; lower id first.
        send_request(ACT_TICK, '0, 1'b0, '0);
        send_request(ACT_CANCEL, '0, 1'b0, TID_W'(2));
        send_request(ACT_CANCEL, '0, 1'b0, TID_W'(2));
        send_request(ACT_CANCEL, '0, 1'b0, TID_W'(1));
    endtask

    task automatic test_table_full_burst();
        int i;
        for (i = 0; i < SLOTS; i++)
            send_request(ACT_ADD, DLY_W'(3), i[0], '0);
        send_request(ACT_ADD, DLY_W'(3), 1'b0, '0);
        // Every slot comes due on the third tick.
        repeat (3) send_request(ACT_TICK, '0, 1'b0, '0);
    endtask

    task automatic test_random_traffic(input int items, input int idle_pct,
                                       input int stall_pct);
        int n;
        int i;
        int pick;
        int span;
        int live[$];
        logic [DLY_W-1:0] dly;
        logic [TID_W-1:0] tid;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (n = 0; n < items; n++) begin
            pick = $urandom_range(99);
            span = $urandom_range(9);
            if (span < 8)
                dly = DLY_W'($urandom_range(0, 6));
            else if (span == 8)
                dly = DLY_W'($urandom_range(7, 64));
            else
                dly = DLY_W'($urandom());
            tid = TID_W'($urandom());
            if (pick < 35) begin
                send_request(ACT_ADD, dly, 1'($urandom_range(1)), tid);
            end else if (pick < 52) begin
                // Mostly target a live timer so cancels actually free slots.
                live.delete();
                for (i = 0; i < SLOTS; i++)
                    if (timer_on[i]) live.push_back(i);
                if (live.size() > 0 && $urandom_range(9) < 7)
                    tid = TID_W'(live[$urandom_range(live.size() - 1)]);
                send_request(ACT_CANCEL, dly, 1'($urandom_range(1)), tid);
            end else if (pick < 96) begin
                send_request(ACT_TICK, dly, 1'($urandom_range(1)), tid);
            end else begin
                send_request(ACT_UNUSED, dly, 1'($urandom_range(1)), tid);
            end
        end
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_quiet_and_unused();
        test_add_fire_cancel();
        test_table_full_burst();
        test_random_traffic(82, 0, 0);
        test_random_traffic(82, 58, 0);
        test_random_traffic(82, 0, 58);
        test_random_traffic(82, 26, 26);

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("requests: %0d, results checked: %0d, failures: %0d",
                 requests_sent, results_checked, errors);
        $display("timers fired: %0d, table-full answers: %0d, final time %0d",
                 fires_predicted, fulls_predicted, tick_count);
        if (errors == 0)
            $display("deadline_timer_queue: match");
        else
            $display("deadline_timer_queue: mismatch");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/dtq_pkg.sv
hw/rtl/dtq_ram.sv
hw/rtl/dtq_select.sv
hw/rtl/deadline_timer_queue.sv
bench/tb_deadline_timer_queue.sv
